// ----- hw/rtl/bba_pkg.sv -----
// Shared constants, codes and controller/datapath interface types of the block allocator.
`default_nettype none

package bba_pkg;

  localparam int MAX_BLOCKS  = 4096;
  localparam int MAX_REQUEST = 64;

  // Field widths of the interface words.
  localparam int CNT_W = 13;
  localparam int REQ_W = 7;
  localparam int IDX_W = 12;
  localparam int ST_W  = 2;

  // Bitmap organisation: one memory row holds WORD_W block bits.
  localparam int WORD_W    = 32;
  localparam int NUM_WORDS = MAX_BLOCKS / WORD_W;
  localparam int ADDR_W    = $clog2(NUM_WORDS);
  localparam int BIT_W     = $clog2(WORD_W);
  localparam int NW_W      = CNT_W - BIT_W;

  localparam logic [CNT_W-1:0] BLOCK_COUNT_RESET = CNT_W'(4096);

  typedef enum logic [ST_W-1:0] {
    ST_GRANTED = 2'd0,
    ST_NOSPACE = 2'd1,
    ST_FREED   = 2'd2,
    ST_RANGE   = 2'd3
  } status_e;

  typedef enum logic {
    OP_RESERVE = 1'b0,
    OP_FREE    = 1'b1
  } op_e;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_RC_INIT,
    S_RC_RUN,
    S_RC_DRAIN,
    S_IDLE,
    S_DISPATCH,
    S_EMIT_RANGE,
    S_EMIT_NOSPACE,
    S_FR_WAIT,
    S_FR_EMIT,
    S_RS_READ,
    S_RS_LOAD,
    S_RS_SCAN,
    S_RS_WRITE
  } state_e;

  typedef struct packed {
    logic    in_ready;
    logic    addr_clr;
    logic    addr_inc;
    logic    rd_en;
    logic    rd_idx;
    logic    wr_zero;
    logic    wr_cur;
    logic    wr_free;
    logic    rc_init;
    logic    rc_acc;
    logic    rc_load;
    logic    rs_init;
    logic    cur_load;
    logic    grant;
    logic    emit;
    status_e emit_st;
  } bba_cmd_t;

  typedef struct packed {
    logic pending;
    logic addr_last;
    logic is_free;
    logic idx_ok;
    logic req_ok;
    logic has_free;
    logic remain_one;
    logic remain_zero;
    logic out_ready;
    logic in_accept;
  } bba_status_t;

endpackage

`default_nettype wire

// ----- hw/rtl/bba_ctrl.sv -----
// Controller state machine of the block allocator.
`default_nettype none

module bba_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  bba_pkg::bba_status_t status_i,
  output bba_pkg::bba_cmd_t    cmd_o
);
  import bba_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLEAR: begin
        if (status_i.addr_last) state_d = S_RC_INIT;
      end
      S_RC_INIT: state_d = S_RC_RUN;
      S_RC_RUN: begin
        if (status_i.addr_last) state_d = S_RC_DRAIN;
      end
      S_RC_DRAIN: state_d = S_IDLE;
      S_IDLE: begin
        priority if (status_i.pending) begin
          state_d = S_RC_INIT;
        end else if (status_i.in_accept) begin
          state_d = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        priority if (status_i.is_free) begin
          state_d = status_i.idx_ok ? S_FR_WAIT : S_EMIT_RANGE;
        end else begin
          state_d = status_i.req_ok ? S_RS_READ : S_EMIT_NOSPACE;
        end
      end
      S_EMIT_RANGE, S_EMIT_NOSPACE, S_FR_EMIT: begin
        if (status_i.out_ready) state_d = S_IDLE;
      end
      S_FR_WAIT: state_d = S_FR_EMIT;
      S_RS_READ: state_d = S_RS_LOAD;
      S_RS_LOAD: state_d = S_RS_SCAN;
      S_RS_SCAN: begin
        priority if (!status_i.has_free) begin
          state_d = S_RS_WRITE;
        end else if (status_i.out_ready && status_i.remain_one) begin
          state_d = S_RS_WRITE;
        end
      end
      S_RS_WRITE: state_d = status_i.remain_zero ? S_IDLE : S_RS_READ;
      default: state_d = S_CLEAR;
    endcase
  end

  always_comb begin
    cmd_o         = '0;
    cmd_o.emit_st = ST_GRANTED;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.wr_zero  = 1'b1;
        cmd_o.addr_inc = 1'b1;
      end
      S_RC_INIT: begin
        cmd_o.rc_init  = 1'b1;
        cmd_o.addr_clr = 1'b1;
      end
      S_RC_RUN: begin
        cmd_o.rd_en    = 1'b1;
        cmd_o.addr_inc = 1'b1;
        cmd_o.rc_acc   = 1'b1;
      end
      S_RC_DRAIN: begin
        cmd_o.rc_acc  = 1'b1;
        cmd_o.rc_load = 1'b1;
      end
      S_IDLE: cmd_o.in_ready = !status_i.pending;
      S_DISPATCH: begin
        if (status_i.is_free) begin
          cmd_o.rd_en  = status_i.idx_ok;
          cmd_o.rd_idx = 1'b1;
        end else begin
          cmd_o.rs_init  = 1'b1;
          cmd_o.addr_clr = 1'b1;
        end
      end
      S_EMIT_RANGE: begin
        cmd_o.emit    = status_i.out_ready;
        cmd_o.emit_st = ST_RANGE;
      end
      S_EMIT_NOSPACE: begin
        cmd_o.emit    = status_i.out_ready;
        cmd_o.emit_st = ST_NOSPACE;
      end
      S_FR_WAIT: cmd_o.wr_free = 1'b1;
      S_FR_EMIT: begin
        cmd_o.emit    = status_i.out_ready;
        cmd_o.emit_st = ST_FREED;
      end
      S_RS_READ: cmd_o.rd_en = 1'b1;
      S_RS_LOAD: cmd_o.cur_load = 1'b1;
      S_RS_SCAN: cmd_o.grant = status_i.has_free && status_i.out_ready;
      S_RS_WRITE: begin
        cmd_o.wr_cur   = 1'b1;
        cmd_o.addr_inc = 1'b1;
      end
      default: cmd_o.emit_st = ST_GRANTED;
    endcase
  end

endmodule

`default_nettype wire

// ----- hw/rtl/bba_datapath.sv -----
// Datapath of the block allocator: bitmap memory, counters and the output register.
`default_nettype none

module bba_datapath (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        block_count_we_i,
  input  logic [bba_pkg::CNT_W-1:0]   block_count_i,
  input  logic                        in_valid_i,
  input  logic                        operation_i,
  input  logic [bba_pkg::REQ_W-1:0]   request_count_i,
  input  logic [bba_pkg::IDX_W-1:0]   block_index_i,
  input  logic                        out_stall_i,
  output logic                        out_valid_o,
  output logic [bba_pkg::IDX_W-1:0]   granted_block_o,
  output logic [bba_pkg::ST_W-1:0]    status_o,
  output logic                        last_o,
  input  bba_pkg::bba_cmd_t           cmd_i,
  output bba_pkg::bba_status_t        status_out_o
);
  import bba_pkg::*;

  function automatic logic [WORD_W-1:0] word_mask(input logic [ADDR_W-1:0] a,
                                                  input logic [CNT_W-1:0] n);
    logic [NW_W-1:0] nw;
    nw = n[CNT_W-1:BIT_W];
    if (NW_W'(a) < nw) begin
      return '1;
    end else if (NW_W'(a) == nw) begin
      return (WORD_W'(1) << n[BIT_W-1:0]) - WORD_W'(1);
    end else begin
      return '0;
    end
  endfunction

  function automatic logic [BIT_W:0] popcount(input logic [WORD_W-1:0] v);
    logic [3:0]     b;
    logic [BIT_W:0] s;
    s = '0;
    for (int k = 0; k < WORD_W / 8; k++) begin
      b = '0;
      for (int j = 0; j < 8; j++) begin
        b = b + 4'(v[8*k+j]);
      end
      s = s + (BIT_W+1)'(b);
    end
    return s;
  endfunction

  function automatic logic [BIT_W-1:0] lowest(input logic [WORD_W-1:0] v);
    logic [BIT_W-1:0] p;
    p = '0;
    for (int b = WORD_W - 1; b >= 0; b--) begin
      if (v[b]) p = BIT_W'(b);
    end
    return p;
  endfunction

  logic [WORD_W-1:0] mem_q [NUM_WORDS];
  logic [WORD_W-1:0] rdata_q;
  logic [ADDR_W-1:0] rd_addr, rd_addr_q, wr_addr, addr_q;
  logic [WORD_W-1:0] wr_data;
  logic              wr_en, rd_vld_q;

  logic [CNT_W-1:0]  block_count_q, n_act, bc_sat;
  logic              pending_q;
  logic [CNT_W-1:0]  free_total_q, acc_q, acc_d;
  logic [REQ_W-1:0]  remain_q;
  logic [WORD_W-1:0] cur_q, free_vec;
  logic [BIT_W-1:0]  pos;
  logic [IDX_W-1:0]  grant_idx;

  op_e              op_q;
  logic [REQ_W-1:0] req_q;
  logic [IDX_W-1:0] idx_q;
  logic [ADDR_W-1:0] idx_word;
  logic              in_accept, out_ready, out_valid_q;

  assign bc_sat   = (block_count_q > CNT_W'(MAX_BLOCKS)) ? CNT_W'(MAX_BLOCKS) : block_count_q;
  assign n_act    = {bc_sat[CNT_W-1:3], 3'b000};
  assign idx_word = idx_q[IDX_W-1:BIT_W];

  // Bitmap memory: one write and one registered read per cycle.
  assign rd_addr = cmd_i.rd_idx ? idx_word : addr_q;

  always_comb begin
    wr_en   = 1'b1;
    wr_addr = addr_q;
    wr_data = '0;
    priority if (cmd_i.wr_zero) begin
      wr_data = '0;
    end else if (cmd_i.wr_cur) begin
      wr_data = cur_q;
    end else if (cmd_i.wr_free) begin
      wr_addr = idx_word;
      wr_data = rdata_q & ~(WORD_W'(1) << idx_q[BIT_W-1:0]);
    end else begin
      wr_en = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[wr_addr] <= wr_data;
    if (cmd_i.rd_en) rdata_q <= mem_q[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q   <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      rd_vld_q <= cmd_i.rd_en;
      if (cmd_i.addr_clr) begin
        addr_q <= '0;
      end else if (cmd_i.addr_inc) begin
        addr_q <= addr_q + ADDR_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rd_addr_q <= rd_addr;
  end

  // Configuration and the recount that follows every block count write.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      block_count_q <= BLOCK_COUNT_RESET;
      pending_q     <= 1'b0;
    end else begin
      if (block_count_we_i) begin
        block_count_q <= block_count_i;
        pending_q     <= 1'b1;
      end else if (cmd_i.rc_init) begin
        pending_q <= 1'b0;
      end
    end
  end

  assign acc_d = acc_q + (rd_vld_q ?
                 CNT_W'(popcount(~rdata_q & word_mask(rd_addr_q, n_act))) : CNT_W'(0));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q        <= '0;
      free_total_q <= '0;
    end else begin
      if (cmd_i.rc_init) begin
        acc_q <= '0;
      end else if (cmd_i.rc_acc) begin
        acc_q <= acc_d;
      end
      priority if (cmd_i.rc_load) begin
        free_total_q <= acc_d;
      end else if (cmd_i.grant) begin
        free_total_q <= free_total_q - CNT_W'(1);
      end else if (cmd_i.wr_free && rdata_q[idx_q[BIT_W-1:0]]) begin
        free_total_q <= free_total_q + CNT_W'(1);
      end
    end
  end

  // Input word capture.
  assign in_accept = in_valid_i && cmd_i.in_ready;

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      op_q  <= op_e'(operation_i);
      req_q <= request_count_i;
      idx_q <= block_index_i;
    end
  end

  // Reserve scan over the current bitmap word.
  assign free_vec  = ~cur_q & word_mask(addr_q, n_act);
  assign pos       = lowest(free_vec);
  assign grant_idx = {addr_q, pos};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      remain_q <= '0;
    end else if (cmd_i.rs_init) begin
      remain_q <= req_q;
    end else if (cmd_i.grant) begin
      remain_q <= remain_q - REQ_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cur_load) begin
      cur_q <= rdata_q;
    end else if (cmd_i.grant) begin
      cur_q[pos] <= 1'b1;
    end
  end

  // Output register: a finished word waits here while the next input is taken.
  assign out_ready = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.grant || cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.grant) begin
      granted_block_o <= grant_idx;
      status_o        <= ST_GRANTED;
      last_o          <= (remain_q == REQ_W'(1));
    end else if (cmd_i.emit) begin
      granted_block_o <= '0;
      status_o        <= cmd_i.emit_st;
      last_o          <= 1'b1;
    end
  end

  assign out_valid_o = out_valid_q;

  always_comb begin
    status_out_o             = '0;
    status_out_o.pending     = pending_q;
    status_out_o.addr_last   = (addr_q == ADDR_W'(NUM_WORDS - 1));
    status_out_o.is_free     = (op_q == OP_FREE);
    status_out_o.idx_ok      = ({1'b0, idx_q} < n_act);
    status_out_o.req_ok      = (req_q != '0) && (req_q <= REQ_W'(MAX_REQUEST)) &&
                               (free_total_q >= CNT_W'(req_q));
    status_out_o.has_free    = (free_vec != '0);
    status_out_o.remain_one  = (remain_q == REQ_W'(1));
    status_out_o.remain_zero = (remain_q == '0);
    status_out_o.out_ready   = out_ready;
    status_out_o.in_accept   = in_accept;
  end

`ifndef ASSERT_OFF
  a_grant_has_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.grant |-> (free_vec != '0) && out_ready)
    else $error("grant issued without a free bit or an output slot");

  a_grant_has_budget: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.grant |-> (free_total_q != '0) && (remain_q != '0))
    else $error("grant issued with no free blocks or nothing left to reserve");

  a_grant_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.grant |-> ({1'b0, grant_idx} < n_act))
    else $error("granted block lies beyond the block count");
`endif

endmodule

`default_nettype wire

// ----- hw/rtl/bitmap_block_allocator.sv -----
// Top level of the bitmap first-fit block allocator.
`default_nettype none

// Keeps one used/free bit per block in a 128 x 32-bit bitmap memory. A reserve word
// grants the lowest-numbered free blocks, one result word per block with last on the
// final one, or gives a single no-space word; a free word clears one bit and answers
// freed or index-out-of-range. Timing is set by the single memory port and the word
// scan: a free reads its bitmap word, writes it back and answers; a reserve reads,
// loads, scans and writes back each 32-block bitmap word up to the last granted
// block, granting while the output is not stalled; any answer also waits on a stalled
// output. After reset a clearing pass and a free count pass run before the first
// input word is taken; every write of block_count starts a recount, and input is
// stalled after the write until the recount has finished.
module bitmap_block_allocator (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      block_count_we_i,
  input  logic [bba_pkg::CNT_W-1:0] block_count_i,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic                      operation_i,
  input  logic [bba_pkg::REQ_W-1:0] request_count_i,
  input  logic [bba_pkg::IDX_W-1:0] block_index_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [bba_pkg::IDX_W-1:0] granted_block_o,
  output logic [bba_pkg::ST_W-1:0]  status_o,
  output logic                      last_o
);
  import bba_pkg::*;

  bba_cmd_t    cmd;
  bba_status_t status;

  bba_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .cmd_o    (cmd)
  );

  bba_datapath u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .block_count_we_i (block_count_we_i),
    .block_count_i    (block_count_i),
    .in_valid_i       (in_valid_i),
    .operation_i      (operation_i),
    .request_count_i  (request_count_i),
    .block_index_i    (block_index_i),
    .out_stall_i      (out_stall_i),
    .out_valid_o      (out_valid_o),
    .granted_block_o  (granted_block_o),
    .status_o         (status_o),
    .last_o           (last_o),
    .cmd_i            (cmd),
    .status_out_o     (status)
  );

  assign in_stall_o = !cmd.in_ready;

endmodule

`default_nettype wire
